### design/sdwt_pkg.sv
// ----------------------------------------------------------------------------
// Segmented deadline wait timer package
// Widths, codes, reset values and the structs shared by the timer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sdwt_pkg;

  localparam int unsigned TimeW    = 48;
  localparam int unsigned GenW     = 32;
  localparam int unsigned DurW     = 32;
  localparam int unsigned CountW   = 8;
  localparam int unsigned ErrW     = 3;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ProdW    = DurW + CountW;

  // Register reset values.
  localparam logic [DurW-1:0]   TotalDurationReset = DurW'(7300000);
  localparam logic [DurW-1:0]   SliceLengthReset   = DurW'(1460000);
  localparam logic [CountW-1:0] SliceLimitReset    = CountW'(5);

  // Event kinds.
  typedef enum logic [KindW-1:0] {
    KIND_BEGIN   = 2'd0,
    KIND_POLL    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_STATUS  = 2'd3
  } kind_t;

  // Result error codes.
  typedef enum logic [ErrW-1:0] {
    ERR_OK             = 3'd0,
    ERR_CLOCK_BACK     = 3'd1,
    ERR_ALREADY_ACTIVE = 3'd2,
    ERR_NOT_ACTIVE     = 3'd3,
    ERR_SEGMENT        = 3'd4,
    ERR_RESTART_EARLY  = 3'd5
  } err_t;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] CFG_TOTAL_DURATION = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_SLICE_LENGTH   = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_SLICE_LIMIT    = 2'd2;

  typedef struct packed {
    logic [DurW-1:0]   total_duration;
    logic [DurW-1:0]   slice_length;
    logic [CountW-1:0] slice_limit;
  } timer_cfg_t;

  typedef struct packed {
    logic              armed;
    logic              start_valid;
    logic [TimeW-1:0]  start_time;
    logic              last_valid;
    logic [TimeW-1:0]  last_time;
    logic [GenW-1:0]   gen_id;
    logic [CountW-1:0] slices_used;
    logic [DurW-1:0]   deadline;
  } timer_state_t;

  typedef struct packed {
    kind_t            kind;
    logic [TimeW-1:0] now_ms;
    logic [GenW-1:0]  generation;
  } event_t;

  typedef struct packed {
    err_t              error_code;
    logic              deadline_reached;
    logic              full_wait_done;
    logic              is_active;
    logic              has_started;
    logic [TimeW-1:0]  elapsed_time;
    logic [CountW-1:0] slice_count;
    logic [GenW-1:0]   current_generation;
    logic [DurW-1:0]   cur_deadline;
  } result_t;

endpackage

`default_nettype wire

### design/sdwt_evt_if.sv
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel carrying one timer event word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdwt_evt_if;
  logic                       valid;
  logic                       ready;
  logic [sdwt_pkg::KindW-1:0] kind;
  logic [sdwt_pkg::TimeW-1:0] now_ms;
  logic [sdwt_pkg::GenW-1:0]  generation;

  modport source (output valid, output kind, output now_ms, output generation,
                  input ready);
  modport sink   (input valid, input kind, input now_ms, input generation,
                  output ready);
endinterface

`default_nettype wire

### design/sdwt_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one timer result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdwt_res_if;
  logic                        valid;
  logic                        ready;
  logic [sdwt_pkg::ErrW-1:0]   error_code;
  logic                        deadline_reached;
  logic                        full_wait_done;
  logic                        is_active;
  logic                        has_started;
  logic [sdwt_pkg::TimeW-1:0]  elapsed_time;
  logic [sdwt_pkg::CountW-1:0] slice_count;
  logic [sdwt_pkg::GenW-1:0]   current_generation;
  logic [sdwt_pkg::DurW-1:0]   cur_deadline;

  modport source (output valid, output error_code, output deadline_reached,
                  output full_wait_done, output is_active, output has_started,
                  output elapsed_time, output slice_count,
                  output current_generation, output cur_deadline,
                  input ready);
  modport sink   (input valid, input error_code, input deadline_reached,
                  input full_wait_done, input is_active, input has_started,
                  input elapsed_time, input slice_count,
                  input current_generation, input cur_deadline,
                  output ready);
endinterface

`default_nettype wire

### design/sdwt_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdwt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sdwt_pkg::CfgAddrW-1:0] addr;
  logic [sdwt_pkg::CfgDataW-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

### design/sdwt_eval.sv
// ----------------------------------------------------------------------------
// Timer event evaluation
// Combinational next state and result word for one event against the
// current timer state and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module sdwt_eval (
  input  sdwt_pkg::timer_state_t st,
  input  sdwt_pkg::timer_cfg_t   cfg,
  input  sdwt_pkg::event_t       ev,
  output sdwt_pkg::timer_state_t st_next,
  output sdwt_pkg::result_t      res
);
  import sdwt_pkg::*;

  logic              clock_back;
  logic [TimeW-1:0]  spent;
  logic [CountW-1:0] count_next;
  logic [ProdW-1:0]  prod;
  logic [DurW-1:0]   capped;
  logic [DurW-1:0]   poll_deadline;
  logic              begin_ok;
  logic              clock_back_post;
  logic [TimeW-1:0]  spent_post;
  err_t              err;
  logic              reached;

  // Time checks against the state before the event.
  assign clock_back = st.start_valid &&
                      ((ev.now_ms < st.start_time) ||
                       (st.last_valid && (ev.now_ms < st.last_time)));
  assign spent = (st.start_valid && !clock_back) ? (ev.now_ms - st.start_time)
                                                 : '0;

  // Deadline for a newly opened slice, capped at the full duration.
  assign count_next = st.slices_used + CountW'(1);
  assign prod       = cfg.slice_length * count_next;
  assign capped     = (prod < ProdW'(cfg.total_duration)) ? prod[DurW-1:0]
                                                          : cfg.total_duration;

  // Event handling; every error leaves the state as it was.
  always_comb begin
    st_next       = st;
    err           = ERR_OK;
    reached       = 1'b0;
    begin_ok      = 1'b0;
    poll_deadline = st.deadline;
    unique case (ev.kind)
      KIND_BEGIN: begin
        if (st.armed) begin
          err = ERR_ALREADY_ACTIVE;
        end else begin
          begin_ok            = 1'b1;
          st_next.armed       = 1'b1;
          st_next.start_valid = 1'b1;
          st_next.start_time  = ev.now_ms;
          st_next.last_valid  = 1'b1;
          st_next.last_time   = ev.now_ms;
          st_next.gen_id      = '0;
          st_next.slices_used = '0;
          st_next.deadline    = '0;
        end
      end
      KIND_POLL: begin
        priority if (!st.armed || (ev.generation == '0)) begin
          err = ERR_NOT_ACTIVE;
        end else if (clock_back) begin
          err = ERR_CLOCK_BACK;
        end else if ((ev.generation != st.gen_id) &&
                     ((ev.generation < st.gen_id) ||
                      (st.slices_used >= cfg.slice_limit) ||
                      ((st.gen_id != '0) && (spent < TimeW'(st.deadline))))) begin
          err = ERR_SEGMENT;
        end else begin
          if (ev.generation != st.gen_id) begin
            poll_deadline       = capped;
            st_next.gen_id      = ev.generation;
            st_next.slices_used = count_next;
            st_next.deadline    = capped;
          end
          st_next.last_valid = 1'b1;
          st_next.last_time  = ev.now_ms;
          reached            = spent >= TimeW'(poll_deadline);
        end
      end
      KIND_RESTART: begin
        priority if (!st.armed) begin
          err = ERR_RESTART_EARLY;
        end else if (clock_back) begin
          err = ERR_CLOCK_BACK;
        end else if (spent < TimeW'(cfg.total_duration)) begin
          err = ERR_RESTART_EARLY;
        end else begin
          st_next.armed      = 1'b0;
          st_next.last_valid = 1'b1;
          st_next.last_time  = ev.now_ms;
        end
      end
      KIND_STATUS: begin
        if (clock_back) begin
          err = ERR_CLOCK_BACK;
        end
      end
      default: begin
        err = ERR_OK;
      end
    endcase
  end

  // A successful begin resets the time base; other successful events keep
  // the clock consistent, so the earlier checks still hold after them.
  assign clock_back_post = begin_ok ? 1'b0 : clock_back;
  assign spent_post      = begin_ok ? '0 : spent;

  // Result word reflects the state after the event.
  always_comb begin
    res.error_code         = err;
    res.deadline_reached   = reached;
    res.full_wait_done     = st_next.armed && !clock_back_post &&
                             (spent_post >= TimeW'(cfg.total_duration));
    res.is_active          = st_next.armed;
    res.has_started        = st_next.start_valid;
    res.elapsed_time       = spent_post;
    res.slice_count        = st_next.slices_used;
    res.current_generation = st_next.gen_id;
    res.cur_deadline       = st_next.deadline;
  end

endmodule

`default_nettype wire

### design/segmented_deadline_wait_timer.sv
// ----------------------------------------------------------------------------
// Segmented deadline wait timer
// Long-wait timer armed by begin events, extended in generation slices by
// poll events and disarmed by restart once the full duration has passed.
// ----------------------------------------------------------------------------
//
//   Port   Direction  Contents
//   evt    sink       kind, now_ms, generation
//   res    source     error code, flags, elapsed time, slice state, deadline
//   cfg    sink       addr (0 total duration, 1 slice length, 2 slice limit),
//                     data; always ready
//
// Each event is taken into an input register, evaluated against the timer
// state, and its result word lands in the output register; one event is
// accepted every cycle while the result channel is not stalled.
// The slice deadline multiply (32 x 8) and the 48-bit time compares form the
// single evaluation stage. A stalled output holds the evaluation stage and
// then the input register. Reset clears the state and restores the default
// register values.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_deadline_wait_timer (
  input  wire logic   clk,
  input  wire logic   rst,
  sdwt_evt_if.sink    evt,
  sdwt_res_if.source  res,
  sdwt_cfg_if.sink    cfg
);
  import sdwt_pkg::*;

  timer_cfg_t   cfg_regs;
  timer_state_t state;
  timer_state_t state_next;
  event_t       ev_in;
  logic         ev_valid;
  result_t      res_next;
  result_t      res_word;
  logic         res_valid;
  logic         advance;

  // Configuration writes; indexes beyond the list are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.total_duration <= TotalDurationReset;
      cfg_regs.slice_length   <= SliceLengthReset;
      cfg_regs.slice_limit    <= SliceLimitReset;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        CFG_TOTAL_DURATION: cfg_regs.total_duration <= cfg.data;
        CFG_SLICE_LENGTH:   cfg_regs.slice_length   <= cfg.data;
        CFG_SLICE_LIMIT:    cfg_regs.slice_limit    <= cfg.data[CountW-1:0];
        default:            cfg_regs                <= cfg_regs;
      endcase
    end
  end

  // The evaluation stage moves on whenever the output register is free.
  assign advance   = !res_valid || res.ready;
  assign evt.ready = !ev_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (evt.ready) begin
      ev_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ready && evt.valid) begin
      ev_in.kind       <= kind_t'(evt.kind);
      ev_in.now_ms     <= evt.now_ms;
      ev_in.generation <= evt.generation;
    end
  end

  sdwt_eval u_eval (
    .st      (state),
    .cfg     (cfg_regs),
    .ev      (ev_in),
    .st_next (state_next),
    .res     (res_next)
  );

  // Timer state commits as the result word is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= ev_valid;
      if (ev_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ev_valid) begin
      res_word <= res_next;
    end
  end

  // Output register to the result channel.
  assign res.valid              = res_valid;
  assign res.error_code         = res_word.error_code;
  assign res.deadline_reached   = res_word.deadline_reached;
  assign res.full_wait_done     = res_word.full_wait_done;
  assign res.is_active          = res_word.is_active;
  assign res.has_started        = res_word.has_started;
  assign res.elapsed_time       = res_word.elapsed_time;
  assign res.slice_count        = res_word.slice_count;
  assign res.current_generation = res_word.current_generation;
  assign res.cur_deadline       = res_word.cur_deadline;

endmodule

`default_nettype wire
